// ===== hdl/ttb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

    // Request kinds carried on s_tuser
    localparam logic [2:0] REQ_FINE    = 3'd0;
    localparam logic [2:0] REQ_COARSE  = 3'd1;
    localparam logic [2:0] REQ_QCHECK  = 3'd2;
    localparam logic [2:0] REQ_LOAD    = 3'd3;
    localparam logic [2:0] REQ_TBRST   = 3'd4;
    localparam logic [2:0] REQ_TRIGGER = 3'd5;

    // Timer select for a timer load
    localparam logic [2:0] TMR_ACE      = 3'd0;
    localparam logic [2:0] TMR_BOLT     = 3'd1;
    localparam logic [2:0] TMR_BUCKET   = 3'd2;
    localparam logic [2:0] TMR_DEBOUNCE = 3'd3;
    localparam logic [2:0] TMR_INHIBIT  = 3'd4;
    localparam logic [2:0] TMR_OFFSET   = 3'd5;

    // Power-save modes (code 3 behaves as none)
    localparam logic [1:0] PS_NONE      = 2'd0;
    localparam logic [1:0] PS_IDLE_DOWN = 2'd1;
    localparam logic [1:0] PS_SIM_IDLE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ARS_TIME  = 2'd0;
    localparam logic [1:0] CFG_PSAVE     = 2'd1;
    localparam logic [1:0] CFG_DB_RELOAD = 2'd2;

    // Timebase constants
    localparam logic [7:0] QRTR_RELOAD     = 8'd250;
    localparam logic [7:0] QRTR_PER_MINUTE = 8'd240;
    localparam logic [7:0] QRTR_PER_15S    = 8'd60;
    localparam logic [7:0] QRTR_PER_SECOND = 8'd4;
    localparam logic [7:0] IDLE_MINUTES    = 8'd15;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] trigger_mode;
        logic [2:0] timer_index;
        logic [7:0] load_value;
    } item_t;

    typedef struct packed {
        logic [1:0] ars_delay;
        logic [1:0] powersave_mode;
        logic [7:0] debounce_reload;
    } cfg_t;

    typedef struct packed {
        logic       ars_apply;
        logic       ramp_reset;
        logic       pwr_down;
        logic       idle_request;
        logic [7:0] quarter_count;
        logic [7:0] minute_count;
    } tb_status_t;

    typedef struct packed {
        logic       trigger_request;
        logic       trigger_blocked;
        logic [7:0] tick_count;
        logic [7:0] fine_count;
        logic       debounce_busy;
    } tmr_status_t;

    // Down-count that sticks at zero
    function automatic logic [7:0] drain8(input logic [7:0] t);
        return (t != 8'd0) ? (t - 8'd1) : t;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ttb_timebase.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttb_timebase (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire ttb_pkg::item_t     item,
    input  wire ttb_pkg::cfg_t      cfg,
    output ttb_pkg::tb_status_t     status
);
    import ttb_pkg::*;

    logic [7:0] qtimer_reg, qtimer_next;
    logic [7:0] qsec_reg,   qsec_next;
    logic [7:0] min_reg,    min_next;
    logic [7:0] qsec_inc;
    logic [7:0] ars_limit;
    logic       ars, ramp, pdown, idle;

    assign qsec_inc  = qsec_reg + 8'd1;
    assign ars_limit = 8'(cfg.ars_delay) * QRTR_PER_15S;

    // Timebase update for the item in flight
    always_comb begin
        qtimer_next = qtimer_reg;
        qsec_next   = qsec_reg;
        min_next    = min_reg;
        ars   = 1'b0;
        ramp  = 1'b0;
        pdown = 1'b0;
        idle  = 1'b0;
        unique case (item.req_type)
            REQ_COARSE: begin
                qtimer_next = drain8(qtimer_reg);
            end
            REQ_QCHECK: begin
                if (qtimer_reg == 8'd0) begin
                    qtimer_next = QRTR_RELOAD;
                    if (qsec_inc >= QRTR_PER_MINUTE) begin
                        min_next  = min_reg + 8'd1;
                        qsec_next = 8'd0;
                    end else begin
                        qsec_next = qsec_inc;
                    end
                    if (item.trigger_mode == 8'd0) begin
                        ars  = (cfg.ars_delay != 2'd0) && (qsec_next >= ars_limit);
                        ramp = (qsec_next >= QRTR_PER_SECOND);
                    end
                end
                // power-save checks see the counts after the quarter update
                if (cfg.powersave_mode == PS_IDLE_DOWN) begin
                    if (min_next >= IDLE_MINUTES) begin
                        pdown       = 1'b1;
                        min_next    = 8'd0;
                        qsec_next   = 8'd0;
                        qtimer_next = QRTR_RELOAD;
                    end
                    idle = (qsec_next != 8'd0) || (min_next != 8'd0);
                end else if (cfg.powersave_mode == PS_SIM_IDLE) begin
                    idle = (qsec_next != 8'd0) || (min_next != 8'd0);
                end
            end
            REQ_TBRST: begin
                min_next    = 8'd0;
                qsec_next   = 8'd0;
                qtimer_next = QRTR_RELOAD;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qtimer_reg <= QRTR_RELOAD;
            qsec_reg   <= 8'd0;
            min_reg    <= 8'd0;
        end else if (fire) begin
            qtimer_reg <= qtimer_next;
            qsec_reg   <= qsec_next;
            min_reg    <= min_next;
        end
    end

    assign status.ars_apply     = ars;
    assign status.ramp_reset    = ramp;
    assign status.pwr_down      = pdown;
    assign status.idle_request  = idle;
    assign status.quarter_count = qsec_next;
    assign status.minute_count  = min_next;

    // Quarter count rolls into minutes before it can reach a full minute
    a_qsec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        qsec_reg < QRTR_PER_MINUTE)
        else $error("quarter count out of range");

    // ARS threshold is at least one second, so ramp reset comes with it
    a_ars_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        ars |-> ramp)
        else $error("ars without ramp reset");

    // A power down clears the timebase and leaves nothing idle
    a_pdown_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        pdown |-> (qsec_next == 8'd0 && min_next == 8'd0 && !idle))
        else $error("power down left timebase counts");

endmodule

`default_nettype wire

// ===== hdl/ttb_timers.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttb_timers (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire ttb_pkg::item_t     item,
    input  wire ttb_pkg::cfg_t      cfg,
    output ttb_pkg::tmr_status_t    status
);
    import ttb_pkg::*;

    logic [7:0] coarse_reg,   coarse_next;
    logic [7:0] fine_reg,     fine_next;
    logic [7:0] ace_reg,      ace_next;
    logic [7:0] bolt_reg,     bolt_next;
    logic [7:0] bucket_reg,   bucket_next;
    logic [7:0] debounce_reg, debounce_next;
    logic [7:0] inhibit_reg,  inhibit_next;
    logic       iflag_reg,    iflag_next;
    logic [7:0] offset_reg,   offset_next;
    logic       trig;

    // Timer bank update for the item in flight
    always_comb begin
        coarse_next   = coarse_reg;
        fine_next     = fine_reg;
        ace_next      = ace_reg;
        bolt_next     = bolt_reg;
        bucket_next   = bucket_reg;
        debounce_next = debounce_reg;
        inhibit_next  = inhibit_reg;
        iflag_next    = iflag_reg;
        offset_next   = offset_reg;
        trig          = 1'b0;
        unique case (item.req_type)
            REQ_FINE: begin
                fine_next = fine_reg + 8'd1;
                ace_next  = drain8(ace_reg);
                if (bolt_reg == 8'd0) begin
                    bucket_next = drain8(bucket_reg);
                end
            end
            REQ_COARSE: begin
                coarse_next   = coarse_reg + 8'd1;
                fine_next     = 8'd0;
                bolt_next     = drain8(bolt_reg);
                debounce_next = drain8(debounce_reg);
                offset_next   = drain8(offset_reg);
                // inhibit expiry releases the trigger
                if (inhibit_reg != 8'd0) begin
                    inhibit_next = inhibit_reg - 8'd1;
                    if (inhibit_reg == 8'd1) begin
                        iflag_next = 1'b0;
                    end
                end
            end
            REQ_LOAD: begin
                unique case (item.timer_index)
                    TMR_ACE:      ace_next      = item.load_value;
                    TMR_BOLT:     bolt_next     = item.load_value;
                    TMR_BUCKET:   bucket_next   = item.load_value;
                    TMR_DEBOUNCE: debounce_next = item.load_value;
                    TMR_INHIBIT: begin
                        inhibit_next = item.load_value;
                        iflag_next   = (item.load_value != 8'd0);
                    end
                    TMR_OFFSET:   offset_next   = item.load_value;
                    default: begin
                    end
                endcase
            end
            REQ_TRIGGER: begin
                if (!iflag_reg) begin
                    debounce_next = cfg.debounce_reload;
                    trig          = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coarse_reg   <= 8'd0;
            fine_reg     <= 8'd0;
            ace_reg      <= 8'd0;
            bolt_reg     <= 8'd0;
            bucket_reg   <= 8'd0;
            debounce_reg <= 8'd0;
            inhibit_reg  <= 8'd0;
            iflag_reg    <= 1'b0;
            offset_reg   <= 8'd0;
        end else if (fire) begin
            coarse_reg   <= coarse_next;
            fine_reg     <= fine_next;
            ace_reg      <= ace_next;
            bolt_reg     <= bolt_next;
            bucket_reg   <= bucket_next;
            debounce_reg <= debounce_next;
            inhibit_reg  <= inhibit_next;
            iflag_reg    <= iflag_next;
            offset_reg   <= offset_next;
        end
    end

    assign status.trigger_request = trig;
    assign status.trigger_blocked = iflag_next;
    assign status.tick_count      = coarse_next;
    assign status.fine_count      = fine_next;
    assign status.debounce_busy   = (debounce_next != 8'd0);

    // The inhibit flag only stands while its timer is running
    a_iflag_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        iflag_reg |-> (inhibit_reg != 8'd0))
        else $error("inhibit flag set with expired timer");

    // An accepted trigger edge is never reported as blocked
    a_trig_unblocked: assert property (@(posedge aclk) disable iff (!aresetn)
        trig |-> !iflag_next)
        else $error("trigger accepted while inhibited");

    // An accepted edge arms the debounce timer with the reload value
    a_trig_debounce: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && trig) |=> (debounce_reg == $past(cfg.debounce_reload)))
        else $error("debounce timer not loaded on trigger");

endmodule

`default_nettype wire

// ===== hdl/tick_timebase_timer_bank_top.sv =====
// Tick timebase and timer bank.
// Input channel s_*: one request per beat. s_tuser carries the request kind
// (fine tick, coarse tick, quarter check, timer load, timebase reset, trigger
// edge); s_tdata carries its arguments. Every request returns exactly one
// result beat on m_*, in order, with the event flags of that request and the
// counter status after it.
// Configuration: cfg_wr_en / cfg_addr / cfg_wdata write ars_delay (0),
// powersave_mode (1) and debounce_reload (2); other indexes are ignored.
// Write only while no request is in flight.
// Path: an accepted beat is held in the input register and, once the result
// register is empty or m_tready is high, is registered as the result on m_*.
// Throughput: one beat per cycle unless m_tready stalls; the timebase and
// timer bank update in one pass of logic between the input and result registers.
// Reset (aresetn low, synchronous) clears all counters and timers, loads the
// quarter timer with 250, clears the configuration, and empties both stages.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, then s_tready drops until m_tready returns.
`timescale 1ns / 1ps
`default_nettype none

module tick_timebase_timer_bank_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: trigger_mode[7:0], timer_index[10:8], load_value[18:11], zero pad
    input  wire logic [ttb_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[2:0]
    input  wire logic [ttb_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: trigger_request[0], trigger_blocked[1], ars_apply[2],
    // ramp_reset[3], pwr_down[4], idle_request[5], quarter_count[13:6],
    // minute_count[21:14], tick_count[29:22], fine_count[37:30],
    // debounce_busy[38], zero pad
    output logic [ttb_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_addr,
    input  wire logic [7:0]                     cfg_wdata
);
    import ttb_pkg::*;

    logic        in_valid_reg, in_valid_next;
    item_t       item_reg;
    logic        out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    cfg_t        cfg_reg;
    logic        fire;
    logic        s_beat;
    tb_status_t  tb_status;
    tmr_status_t tmr_status;

    // Stage handshake
    assign fire   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_beat = s_tvalid && s_tready;

    assign in_valid_next  = s_beat ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ARS_TIME:  cfg_reg.ars_delay       <= cfg_wdata[1:0];
                CFG_PSAVE:     cfg_reg.powersave_mode  <= cfg_wdata[1:0];
                CFG_DB_RELOAD: cfg_reg.debounce_reload <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg <= '0;
        end else if (s_beat) begin
            item_reg.req_type     <= s_tuser;
            item_reg.trigger_mode <= s_tdata[7:0];
            item_reg.timer_index  <= s_tdata[10:8];
            item_reg.load_value   <= s_tdata[18:11];
        end
    end

    ttb_timebase u_timebase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .status  (tb_status)
    );

    ttb_timers u_timers (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .status  (tmr_status)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {1'b0,
                             tmr_status.debounce_busy,
                             tmr_status.fine_count,
                             tmr_status.tick_count,
                             tb_status.minute_count,
                             tb_status.quarter_count,
                             tb_status.idle_request,
                             tb_status.pwr_down,
                             tb_status.ramp_reset,
                             tb_status.ars_apply,
                             tmr_status.trigger_blocked,
                             tmr_status.trigger_request};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A stalled result beat must not be overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !fire)
        else $error("result overwritten while stalled");

    // An item waiting in the input register leaves only into the result stage
    a_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !s_beat && fire) |=> (!in_valid_reg && out_valid_reg))
        else $error("input stage lost an item");

    // Each processed item produces a valid result beat next cycle
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule

`default_nettype wire
